// File: sv/iss_pkg.sv
`timescale 1ns / 1ps
// iss_pkg: shared constants, opcodes, state type and control structs
// for the indexed sequence store; no dependencies

package iss_pkg;

    // capacity must fit the 9-bit count field of the result beat
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 9;
    localparam int OP_W     = 3;
    localparam int POS_W    = 9;
    localparam int VAL_W    = 16;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_FRONT  = 3'd3,
        OP_BACK   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FETCH,
        ST_SHIFT,
        ST_FLUSH,
        ST_PLACE,
        ST_RESPOND
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic fetch;
        logic capture;
        logic load_src;
        logic shift;
        logic place;
        logic respond;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic req_ok;
        logic need_fetch;
        logic need_shift;
        logic shift_last;
        logic is_insert;
        logic out_free;
    } sts_t;

endpackage

// File: sv/iss_req_if.sv
`timescale 1ns / 1ps
// iss_req_if: request channel (opcode, position, new value) with valid/ready
// depends on iss_pkg

interface iss_req_if
    import iss_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] new_value;

    modport source (output valid, output opcode, output position, output new_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input new_value,
                    output ready);
endinterface

// File: sv/iss_res_if.sv
`timescale 1ns / 1ps
// iss_res_if: result channel (ok, value, count, empty flag) with valid/ready
// depends on iss_pkg

interface iss_res_if
    import iss_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] count;
    logic             empty_res;

    modport source (output valid, output ok, output read_value, output count,
                    output empty_res, input ready);
    modport sink   (input valid, input ok, input read_value, input count,
                    input empty_res, output ready);
endinterface

// File: sv/iss_ram.sv
`timescale 1ns / 1ps
// iss_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module iss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/iss_ctrl.sv
`timescale 1ns / 1ps
// iss_ctrl: sequencer for one request at a time
// depends on iss_pkg

module iss_ctrl
    import iss_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    input  sts_t   sts,
    output logic   req_ready,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (!sts.req_ok)
                begin
                    state_next = ST_RESPOND;
                end
                else if (sts.need_fetch)
                begin
                    state_next = ST_FETCH;
                end
                else if (sts.need_shift)
                begin
                    state_next = ST_SHIFT;
                end
                else if (sts.is_insert)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    state_next = ST_RESPOND;
                end
            end
            ST_FETCH:
            begin
                state_next = sts.need_shift ? ST_SHIFT : ST_RESPOND;
            end
            ST_SHIFT:
            begin
                if (sts.shift_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = sts.is_insert ? ST_PLACE : ST_RESPOND;
            end
            ST_PLACE:
            begin
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            ST_DISPATCH:
            begin
                cmd.fetch    = sts.req_ok && sts.need_fetch;
                cmd.load_src = sts.req_ok && !sts.need_fetch && sts.need_shift;
            end
            ST_FETCH:
            begin
                cmd.capture  = 1'b1;
                cmd.load_src = sts.need_shift;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd = '0;
            end
            ST_PLACE:
            begin
                cmd.place = 1'b1;
            end
            ST_RESPOND:
            begin
                cmd.respond = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_respond_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESPOND && sts.out_free) |=> (state_reg == ST_IDLE))
        else $error("respond did not return to idle");

    a_shift_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && !sts.shift_last) |=> (state_reg == ST_SHIFT))
        else $error("shift run ended early");

endmodule

// File: sv/iss_dp.sv
`timescale 1ns / 1ps
// iss_dp: request registers, entry count, shift pointers, entry ram, result register
// depends on iss_pkg, iss_req_if, iss_res_if, iss_ram

module iss_dp
    import iss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    iss_req_if.sink      req,
    iss_res_if.source    res,
    input  cmd_t         cmd,
    output sts_t         sts
);

    logic [OP_W-1:0]   op_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  nval_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  src_reg;
    logic [CNT_W-1:0]  src_next;
    logic              pend_valid_reg;
    logic [ADDR_W-1:0] pend_dst_reg;

    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [VAL_W-1:0]  out_val_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_empty_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    logic              is_take;
    logic [CNT_W-1:0]  pos_plus1;
    logic [CNT_W-1:0]  count_m1;

    assign pos_plus1 = pos_reg + CNT_W'(1);
    assign count_m1  = count_reg - CNT_W'(1);
    assign is_take   = (op_reg == OP_REMOVE) || (op_reg == OP_FRONT) || (op_reg == OP_BACK);

    // status decode
    always_comb
    begin
        sts.is_insert  = op_reg == OP_INSERT;
        sts.shift_last = sts.is_insert ? (src_reg == pos_reg) : (src_reg == count_m1);
        sts.out_free   = !out_valid_reg || res.ready;
        sts.req_ok     = 1'b0;
        sts.need_fetch = 1'b0;
        sts.need_shift = 1'b0;
        unique case (op_reg)
            OP_READ:
            begin
                sts.req_ok     = pos_reg < count_reg;
                sts.need_fetch = 1'b1;
            end
            OP_INSERT:
            begin
                sts.req_ok     = (pos_reg <= count_reg) && (count_reg < CNT_W'(CAPACITY));
                sts.need_shift = pos_reg < count_reg;
            end
            OP_REMOVE:
            begin
                sts.req_ok     = pos_reg < count_reg;
                sts.need_shift = pos_plus1 < count_reg;
            end
            OP_FRONT:
            begin
                sts.req_ok     = count_reg != '0;
                sts.need_fetch = 1'b1;
                sts.need_shift = pos_plus1 < count_reg;
            end
            OP_BACK:
            begin
                sts.req_ok     = count_reg != '0;
                sts.need_fetch = 1'b1;
            end
            default:
            begin
                sts.req_ok = 1'b0;
            end
        endcase
    end

    // ram port steering
    always_comb
    begin
        ram_re    = cmd.fetch || cmd.shift;
        ram_raddr = cmd.shift ? src_reg[ADDR_W-1:0] : pos_reg[ADDR_W-1:0];
        if (pend_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_dst_reg;
            ram_wdata = ram_rdata;
        end
        else
        begin
            ram_we    = cmd.place;
            ram_waddr = pos_reg[ADDR_W-1:0];
            ram_wdata = nval_reg;
        end
    end

    iss_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        src_next = src_reg;
        if (cmd.load_src)
        begin
            src_next = sts.is_insert ? count_m1 : pos_plus1;
        end
        else if (cmd.shift)
        begin
            src_next = sts.is_insert ? (src_reg - CNT_W'(1)) : (src_reg + CNT_W'(1));
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (sts.req_ok)
        begin
            if (sts.is_insert)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (is_take)
            begin
                count_next = count_m1;
            end
        end
    end

    // request payload, fetched value, shift pointers and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= req.opcode;
            nval_reg <= req.new_value;
            val_reg  <= '0;
            if (req.opcode == OP_FRONT)
            begin
                pos_reg <= '0;
            end
            else if (req.opcode == OP_BACK)
            begin
                pos_reg <= count_m1;
            end
            else
            begin
                pos_reg <= req.position;
            end
        end
        if (cmd.capture)
        begin
            val_reg <= ram_rdata;
        end
        src_reg <= src_next;
        if (cmd.shift)
        begin
            pend_dst_reg <= sts.is_insert ? ADDR_W'(src_reg + CNT_W'(1))
                                          : ADDR_W'(src_reg - CNT_W'(1));
        end
        if (cmd.respond)
        begin
            out_ok_reg    <= sts.req_ok;
            out_val_reg   <= val_reg;
            out_count_reg <= count_next;
            out_empty_reg <= count_next == '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= cmd.shift;
            if (cmd.respond)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.ok         = out_ok_reg;
    assign res.read_value = out_val_reg;
    assign res.count      = out_count_reg;
    assign res.empty_res  = out_empty_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_count_on_respond: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(cmd.respond))
        else $error("entry count moved outside respond");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && cmd.shift) |-> (pend_dst_reg != src_reg[ADDR_W-1:0]))
        else $error("shift write and read hit one entry");

endmodule

// File: sv/indexed_sequence_store.sv
`timescale 1ns / 1ps
// indexed_sequence_store: ordered list of up to 256 16-bit entries, positional access
// rejected requests and removes with nothing to move go straight to the result beat;
// read, take back and take front fetch the entry first; remove, insert and take front
// shift any entries beyond the position, then insert places the new value; idle again
// once the result is parked, a held result beat stalls it; async active-low reset
// empties the list; depends on iss_pkg, iss_req_if, iss_res_if, iss_ram, iss_ctrl, iss_dp

module indexed_sequence_store
    import iss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    iss_req_if.sink    req,
    iss_res_if.source  res
);

    // controller to datapath command bundle, and status back
    cmd_t cmd;
    sts_t sts;
    logic ctrl_ready;

    // request beat taken only in idle, one at a time
    assign req.ready = ctrl_ready;

    // sequencer: dispatch, fetch, shift run, flush, place, respond
    iss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .sts       (sts),
        .req_ready (ctrl_ready),
        .cmd       (cmd)
    );

    // entry ram, count, shift pointers and the result register
    // a shift moves one entry a cycle: one ram read ahead, one write behind
    // the result register frees the controller once the beat is parked
    iss_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for indexed_sequence_store, with its own list predictor
// depends on iss_pkg, iss_req_if, iss_res_if and the indexed_sequence_store rtl

module tb_top
    import iss_pkg::*;
;

    // opcodes the block ignores; they still produce one result beat
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

    localparam int unsigned POS_MAX      = (1 << POS_W) - 1;
    localparam int unsigned WANDER_SIZE  = 16;    // size the wandering mix hovers around
    localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int unsigned TAIL_CYCLES  = 300;   // worst shift loop plus margin
    localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no beat on either side

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] new_value;
    } list_req_t;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] read_value;
        logic [CNT_W-1:0] count;
        logic             empty_res;
    } list_res_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // channels and the block
    iss_req_if req_ch ();
    iss_res_if res_ch ();

    indexed_sequence_store dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // driven registers, known from time zero
    logic        req_valid_q = 1'b0;
    list_req_t   req_beat_q  = '0;
    logic        res_ready_q = 1'b0;

    assign req_ch.valid     = req_valid_q;
    assign req_ch.opcode    = req_beat_q.opcode;
    assign req_ch.position  = req_beat_q.position;
    assign req_ch.new_value = req_beat_q.new_value;
    assign res_ch.ready     = res_ready_q;

    // request beats waiting to be offered, and results predicted for accepted beats
    list_req_t   pending_requests[$];
    list_res_t   predicted_results[$];

    // predictor state: the list as it should stand after every accepted request
    logic [VAL_W-1:0] list_copy[$];

    // size the list will have once every queued request has gone through
    int unsigned plan_len = 0;

    int unsigned send_idle_pct = 22;
    int unsigned recv_idle_pct = 57;
    int unsigned hold_left     = 0;
    logic        hold_go       = 1'b0;
    int unsigned mismatches    = 0;
    int unsigned quiet_cycles  = 0;
    list_res_t   head_result;

    // apply one request to the list copy and return the result beat it should give
    function automatic list_res_t predict_list_op(list_req_t r);
        list_res_t   o;
        int unsigned len;
        len = list_copy.size();
        o   = '0;
        case (r.opcode)
            OP_READ:
                if (r.position < len)
                begin
                    o.read_value = list_copy[r.position];
                    o.ok         = 1'b1;
                end
            OP_INSERT:
                if (r.position <= len && len < CAPACITY)
                begin
                    list_copy.insert(r.position, r.new_value);
                    o.ok = 1'b1;
                end
            OP_REMOVE:
                if (r.position < len)
                begin
                    list_copy.delete(r.position);
                    o.ok = 1'b1;
                end
            OP_FRONT:
                if (len > 0)
                begin
                    o.read_value = list_copy.pop_front();
                    o.ok         = 1'b1;
                end
            OP_BACK:
                if (len > 0)
                begin
                    o.read_value = list_copy.pop_back();
                    o.ok         = 1'b1;
                end
            default:
                ;   // unused opcodes leave the list alone
        endcase
        o.count     = CNT_W'(list_copy.size());
        o.empty_res = (list_copy.size() == 0);
        return o;
    endfunction

    // queue a request and track the list size it leaves behind
    task automatic add_request(logic [OP_W-1:0] op, int unsigned pos, logic [VAL_W-1:0] val);
        list_req_t r;
        r.opcode    = op;
        r.position  = pos[POS_W-1:0];
        r.new_value = val;
        pending_requests.push_back(r);
        case (op)
            OP_INSERT:
                if (pos <= plan_len && plan_len < CAPACITY)
                    plan_len++;
            OP_REMOVE:
                if (pos < plan_len)
                    plan_len--;
            OP_FRONT, OP_BACK:
                if (plan_len > 0)
                    plan_len--;
            default:
                ;
        endcase
    endtask

    // mostly valid positions, some just past the end, some anywhere in the field
    function automatic int unsigned pick_position(logic [OP_W-1:0] op);
        int unsigned span;
        int unsigned roll;
        span = (op == OP_INSERT) ? plan_len + 1 : plan_len;
        roll = $urandom_range(0, 19);
        if (span == 0 || roll == 0)
            return $urandom_range(0, POS_MAX);
        if (roll == 1)
            return span;
        return $urandom_range(0, span - 1);
    endfunction

    // values weighted towards the extremes
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // random mix that keeps the list small, so shifts stay short
    task automatic add_wander(int unsigned n);
        int unsigned      sel;
        int unsigned      grow;
        logic [OP_W-1:0]  op;
        repeat (n)
        begin
            sel  = $urandom_range(0, 99);
            grow = (plan_len < WANDER_SIZE) ? 60 : 25;
            if (sel < 5)
                op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            else if (sel < grow)
                op = OP_INSERT;
            else
                case (sel % 4)
                    0:       op = OP_READ;
                    1:       op = OP_REMOVE;
                    2:       op = OP_FRONT;
                    default: op = OP_BACK;
                endcase
            add_request(op, pick_position(op), pick_value());
        end
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    // sampled at the falling edge, once the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_requests.size() != 0 || req_valid_q || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    // request driver: predict on acceptance, then offer the next beat or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid_q && req_ch.ready)
                predicted_results.push_back(predict_list_op(req_beat_q));
            if (!req_valid_q || req_ch.ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_beat_q  <= pending_requests.pop_front();
                    req_valid_q <= 1'b1;
                end
                else
                begin
                    req_valid_q <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here so the monitor only sees a level
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
    end

    // result monitor: compare each beat with the oldest prediction, field by field
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ready_q)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with none expected, expected none, actual %0h %0h %0h %0h",
                             $time, res_ch.ok, res_ch.read_value, res_ch.count, res_ch.empty_res);
                end
                else
                begin
                    head_result = predicted_results.pop_front();
                    if (res_ch.ok !== head_result.ok)
                    begin
                        mismatches++;
                        $display("%0t: ok mismatch, expected %0h, actual %0h",
                                 $time, head_result.ok, res_ch.ok);
                    end
                    if (res_ch.read_value !== head_result.read_value)
                    begin
                        mismatches++;
                        $display("%0t: read_value mismatch, expected %0h, actual %0h",
                                 $time, head_result.read_value, res_ch.read_value);
                    end
                    if (res_ch.count !== head_result.count)
                    begin
                        mismatches++;
                        $display("%0t: count mismatch, expected %0h, actual %0h",
                                 $time, head_result.count, res_ch.count);
                    end
                    if (res_ch.empty_res !== head_result.empty_res)
                    begin
                        mismatches++;
                        $display("%0t: empty_res mismatch, expected %0h, actual %0h",
                                 $time, head_result.empty_res, res_ch.empty_res);
                    end
                end
            end
            res_ready_q <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog: too long with no beat on either channel means the block is stuck
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid_q && req_ch.ready) || (res_ch.valid && res_ready_q))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned     sel;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: everything rejected on an empty list
        add_request(OP_READ,   0, 16'h1234);
        add_request(OP_FRONT,  0, '0);
        add_request(OP_BACK,   0, '0);
        add_request(OP_REMOVE, 0, '0);
        add_request(OP_INSERT, 1, 16'h4321);          // past the end
        // build a small list: insert on empty, push, append, middle insert
        add_request(OP_INSERT, 0, 16'hFFFF);
        add_request(OP_INSERT, 0, 16'h0000);
        add_request(OP_INSERT, 2, 16'h8001);
        add_request(OP_INSERT, 1, 16'h5A5A);
        add_request(OP_READ,   0, '0);
        add_request(OP_READ,   3, '0);
        add_request(OP_READ,   4, '0);                 // one past the last entry
        add_request(OP_READ,   POS_MAX, '1);           // every position bit set
        add_request(OP_INSERT, CAPACITY, 16'h7777);    // far past the end
        add_request(OP_FIRST_UNUSED, 0, '1);
        add_request(OP_W'(OP_FIRST_UNUSED + 3'd1), 1, 16'hAAAA);
        add_request(OP_LAST_UNUSED, POS_MAX, 16'h5555);
        add_request(OP_REMOVE, 1, '0);
        add_request(OP_FRONT,  0, '0);
        add_request(OP_BACK,   0, '0);
        add_request(OP_REMOVE, 3, '0);                 // bad position on a short list
        add_request(OP_REMOVE, 0, '0);                 // last entry goes, list empty again
        add_request(OP_BACK,   0, '0);

        // random, list kept small
        add_wander(100);
        wait_drained();

        // sender idles more than the receiver; fill to the top
        send_idle_pct = 57;
        recv_idle_pct = 22;
        while (plan_len < CAPACITY)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 68)
                add_request(OP_INSERT, plan_len, pick_value());      // append
            else if (sel < 80)
                add_request(OP_INSERT, pick_position(OP_INSERT), pick_value());
            else if (sel < 88)
                add_request(OP_READ, pick_position(OP_READ), pick_value());
            else if (sel < 90)
                add_request(OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)),
                            $urandom_range(0, POS_MAX), pick_value());
            else if (sel < 95)
                add_request(OP_REMOVE, pick_position(OP_REMOVE), '0);
            else
                add_request(OP_BACK, 0, '0);
        end

        // full store: every insert bounces, reads at the far end still work
        add_request(OP_INSERT, 0, '1);
        add_request(OP_INSERT, CAPACITY, '0);
        add_request(OP_READ,   CAPACITY - 1, '0);
        add_request(OP_READ,   CAPACITY, '0);
        repeat (8)
            add_request(OP_INSERT, $urandom_range(0, POS_MAX), pick_value());
        wait_drained();

        // no idling; receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;

        // drain to empty, mostly from the tail
        while (plan_len > 0)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                add_request(OP_BACK, 0, '0);
            else if (sel < 65)
                add_request(OP_REMOVE, plan_len - 1, '0);
            else if (sel < 73)
                add_request(OP_FRONT, 0, '0);
            else if (sel < 80)
                add_request(OP_REMOVE, pick_position(OP_REMOVE), '0);
            else if (sel < 92)
                add_request(OP_READ, pick_position(OP_READ), '0);
            else if (sel < 94)
                add_request(OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)),
                            $urandom_range(0, POS_MAX), pick_value());
            else
                add_request(OP_INSERT, pick_position(OP_INSERT), pick_value());
        end
        wait_drained();

        // back-to-back random mix starting from empty
        add_wander(40);
        wait_drained();

        // let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
sv/iss_pkg.sv
sv/iss_req_if.sv
sv/iss_res_if.sv
sv/iss_ram.sv
sv/iss_ctrl.sv
sv/iss_dp.sv
sv/indexed_sequence_store.sv
tb/tb_top.sv
